>>> sv/encc_pkg.sv
// Package for the nearest-call elevator controller: item types, codes and sizes.
// Used by encc_ctrl, encc_datapath and the top level elevator_nearest_call_controller.
// Depends on nothing else.
package encc_pkg;

    // Floors that the pending-call bitmap and the scan cover.
    localparam int FLOORS_MAX = 16;
    localparam int IDX_W      = $clog2(FLOORS_MAX);
    // Field widths fixed by the item format.
    localparam int FLOOR_W    = 5;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;

    // Action codes of an input item.
    localparam logic [ACTION_W-1:0] ACT_CALL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

    // Car status codes of a result item.
    localparam logic [STATUS_W-1:0] STAT_IDLE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MOVING  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_WAITING = 2'd2;

    // Register values after reset.
    localparam logic [FLOOR_W-1:0] FLOORS_RESET = 5'd8;
    localparam logic [FLOOR_W-1:0] FLOOR_BOTTOM = 5'd1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FLOOR_W-1:0]  floor;
    } t_in_item;

    typedef struct packed {
        logic [FLOOR_W-1:0]  car_floor;
        logic [STATUS_W-1:0] car_status;
        logic                active_step;
        logic                arrived;
        logic                rejected;
        logic                dispatched;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic exec;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_need;
        logic scan_last;
    } t_dp_status;

endpackage

>>> sv/encc_ctrl.sv
// Controller state machine of the nearest-call elevator controller.
// Sequences item load, the floor-by-floor call scan and the execute step.
// Depends on encc_pkg.
module encc_ctrl
    import encc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EXEC = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.scan_need ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

>>> sv/encc_datapath.sv
// Datapath of the nearest-call elevator controller: car state, pending-call bitmap,
// floor-count register, call scan registers and the result register.
// Depends on encc_pkg.
module encc_datapath
    import encc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FLOOR_W-1:0] i_cfg_wdata,
    input  t_in_item           i_item,
    input  t_ctl_cmd           i_cmd,
    output t_dp_status         o_status,
    output logic               o_done,
    output t_out_item          o_result
);

    // Architectural state.
    logic [FLOOR_W-1:0]    r_num_floors;
    logic [FLOOR_W-1:0]    r_cur;
    logic [FLOOR_W-1:0]    r_tgt;
    logic                  r_idle;
    logic                  r_waiting;
    logic [FLOORS_MAX-1:0] r_pend;
    // Item and scan registers.
    t_in_item              r_item;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [FLOOR_W-1:0]    r_best_dist;
    // Result.
    logic                  r_done;
    t_out_item             r_res;

    logic [FLOOR_W-1:0]    n_cur;
    logic [FLOOR_W-1:0]    n_tgt;
    logic                  n_idle;
    logic                  n_waiting;
    logic [FLOORS_MAX-1:0] n_pend;
    t_out_item             n_res;

    logic [FLOOR_W-1:0]    floors_used;
    logic                  floor_valid;
    logic [IDX_W-1:0]      floor_idx;
    logic [FLOOR_W-1:0]    scan_floor;
    logic [FLOOR_W-1:0]    scan_dist;
    logic                  scan_take;
    logic                  tick_idle;
    logic [FLOOR_W-1:0]    tick_tgt;

    // Floor count limited to the range that the bitmap covers.
    always_comb begin
        floors_used = r_num_floors;
        if (r_num_floors == '0) begin
            floors_used = FLOOR_BOTTOM;
        end else if (r_num_floors > FLOOR_W'(FLOORS_MAX)) begin
            floors_used = FLOOR_W'(FLOORS_MAX);
        end
    end

    assign floor_valid = (r_item.floor != '0) && (r_item.floor <= floors_used);
    assign floor_idx   = IDX_W'(r_item.floor - FLOOR_BOTTOM);

    // A tick finding the car idle needs the nearest-call scan.
    assign o_status.scan_need = (i_item.action == ACT_TICK) && r_idle && !r_waiting;
    assign o_status.scan_last = (r_idx == IDX_W'(FLOORS_MAX - 1));

    // One floor of the scan: distance to the car and whether it beats the best so far.
    assign scan_floor = FLOOR_W'(r_idx) + FLOOR_BOTTOM;
    assign scan_dist  = (scan_floor > r_cur) ? (scan_floor - r_cur) : (r_cur - scan_floor);
    assign scan_take  = r_pend[r_idx] && (!r_found || (scan_dist < r_best_dist));

    // Execute step: update the car state and form the result.
    always_comb begin
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_idle    = r_idle;
        n_waiting = r_waiting;
        n_pend    = r_pend;
        n_res     = '0;
        tick_idle = r_idle;
        tick_tgt  = r_tgt;
        case (r_item.action)
            ACT_CALL: begin
                if (floor_valid) begin
                    n_pend[floor_idx] = 1'b1;
                end else begin
                    n_res.rejected = 1'b1;
                end
            end
            ACT_DEST: begin
                if (!r_waiting) begin
                    n_res.rejected = 1'b1;
                end else if (r_item.floor == '0) begin
                    n_idle    = 1'b1;
                    n_waiting = 1'b0;
                end else if (!floor_valid) begin
                    n_idle         = 1'b1;
                    n_waiting      = 1'b0;
                    n_res.rejected = 1'b1;
                end else begin
                    n_tgt     = r_item.floor;
                    n_idle    = 1'b0;
                    n_waiting = 1'b0;
                end
            end
            ACT_TICK: begin
                // Dispatch the nearest call found by the scan.
                if (r_idle && !r_waiting && r_found) begin
                    n_pend[r_best_idx] = 1'b0;
                    tick_tgt           = FLOOR_W'(r_best_idx) + FLOOR_BOTTOM;
                    tick_idle          = 1'b0;
                    n_res.dispatched   = 1'b1;
                end
                n_tgt  = tick_tgt;
                n_idle = tick_idle;
                // Move one floor toward the target.
                if (!tick_idle && !r_waiting) begin
                    if (r_cur < tick_tgt) begin
                        n_cur = r_cur + FLOOR_BOTTOM;
                    end else if (r_cur > tick_tgt) begin
                        n_cur = r_cur - FLOOR_BOTTOM;
                    end
                    if (n_cur == tick_tgt) begin
                        n_waiting     = 1'b1;
                        n_res.arrived = 1'b1;
                    end
                    n_res.active_step = 1'b1;
                end
            end
            default: begin
                n_res.rejected = 1'b1;
            end
        endcase
        n_res.car_floor  = n_cur;
        n_res.car_status = n_waiting ? STAT_WAITING : (n_idle ? STAT_IDLE : STAT_MOVING);
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_floors <= FLOORS_RESET;
            r_cur        <= FLOOR_BOTTOM;
            r_tgt        <= FLOOR_BOTTOM;
            r_idle       <= 1'b1;
            r_waiting    <= 1'b0;
            r_pend       <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_floors <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_cur     <= n_cur;
                r_tgt     <= n_tgt;
                r_idle    <= n_idle;
                r_waiting <= n_waiting;
                r_pend    <= n_pend;
            end
            r_done <= i_cmd.exec;
        end
    end

    // Item, scan and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (scan_take) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_idx;
                r_best_dist <= scan_dist;
            end
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTH
    // The car is never idle and waiting at once.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_idle && r_waiting))
        else $error("car idle and waiting at the same time");

    // The car never moves more than one floor per transfer.
    a_one_floor_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_cur) |->
            (r_cur == $past(r_cur) + FLOOR_BOTTOM) || (r_cur == $past(r_cur) - FLOOR_BOTTOM))
        else $error("car moved more than one floor");

    // A dispatch always sets the car moving on the same tick.
    a_dispatch_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.dispatched |-> r_res.active_step)
        else $error("dispatch without motion");

    // Arrival always leaves the car waiting for a destination.
    a_arrive_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.arrived |-> (r_res.car_status == STAT_WAITING) && r_waiting)
        else $error("arrival without waiting state");
`endif

endmodule

>>> sv/elevator_nearest_call_controller.sv
// Top level of the single-car nearest-call elevator controller.
// Instantiates encc_ctrl and encc_datapath; depends on encc_pkg.
//
// An item is taken when start is high and busy is low, and its one result appears on
// o_result with o_done high for exactly one cycle; the receiver cannot stall it, so it
// must take every result as it comes. A tick that finds the car idle goes through the
// nearest-call scan, one floor per cycle over all 16 bitmap floors, then the execute
// step, then the registered result. Any other item goes from the load straight to the
// execute step and its registered result. busy falls in the cycle that shows the
// result, so the next item can be taken in that cycle. The user must write num_floors
// via i_cfg_we and i_cfg_wdata only while no item is in progress; this is not enforced.
module elevator_nearest_call_controller
    import encc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FLOOR_W-1:0] i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_done,
    output t_out_item          o_result
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    // Sequencer.
    encc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Car state, call bitmap and scan.
    encc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
